FILE: hdl/ce8_pkg.sv
// Shared constants, codes and helper functions for the CHIP-8 execution core.
// No dependencies; ce8_alu and the top level import this package.
`default_nettype none
package ce8_pkg;

	localparam int STACK_DEPTH = 16;
	localparam int MEM_BYTES   = 4096;
	localparam int AW          = $clog2(MEM_BYTES);
	localparam int SP_W        = $clog2(STACK_DEPTH + 1);
	localparam int SI_W        = $clog2(STACK_DEPTH);
	localparam int ROWS        = 32;
	localparam int COLS        = 64;
	localparam int FONT_BYTES  = 80;

	localparam logic [AW-1:0] RESET_START = 12'd512;

	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_HALT       = 3'd1;
	localparam logic [2:0] ST_ILLEGAL    = 3'd2;
	localparam logic [2:0] ST_OVERFLOW   = 3'd3;
	localparam logic [2:0] ST_BAD_RET    = 3'd4;
	localparam logic [2:0] ST_BAD_SPRITE = 3'd5;
	localparam logic [2:0] ST_WAIT_KEY   = 3'd6;

	localparam logic [2:0] FN_STEP  = 3'd0;
	localparam logic [2:0] FN_MEMWR = 3'd1;
	localparam logic [2:0] FN_KEY   = 3'd2;
	localparam logic [2:0] FN_TICK  = 3'd3;
	localparam logic [2:0] FN_PIXEL = 3'd4;

	typedef logic [3:0] alu_op_t;

	localparam alu_op_t ALU_MOV  = 4'd0;
	localparam alu_op_t ALU_OR   = 4'd1;
	localparam alu_op_t ALU_AND  = 4'd2;
	localparam alu_op_t ALU_XOR  = 4'd3;
	localparam alu_op_t ALU_ADD  = 4'd4;
	localparam alu_op_t ALU_SUB  = 4'd5;
	localparam alu_op_t ALU_SHR  = 4'd6;
	localparam alu_op_t ALU_SUBN = 4'd7;
	localparam alu_op_t ALU_SHL  = 4'd8;

	localparam logic [7:0] FONT [FONT_BYTES] = '{
		8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
		8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
		8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
		8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
		8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
		8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
		8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
		8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
	};

	function automatic logic [7:0] font_byte(input logic [AW-1:0] a);
		if (a < AW'(FONT_BYTES)) begin
			return FONT[a[6:0]];
		end
		return 8'd0;
	endfunction

	// Column c of a screen row is bit c; sprite bit 7 lands on column col.
	function automatic logic [COLS-1:0] sprite_mask(input logic [7:0] line,
		input logic [5:0] col);
		logic [COLS-1:0]   m0;
		logic [2*COLS-1:0] t;
		m0 = '0;
		for (int b = 0; b < 8; b++) begin
			m0[b] = line[7-b];
		end
		t = {m0, m0} << col;
		return t[2*COLS-1:COLS];
	endfunction

	// Decimal digit sel (0 hundreds, 1 tens, 2 ones) of v.
	function automatic logic [7:0] bcd_digit(input logic [7:0] v, input logic [1:0] sel);
		logic [1:0]  h;
		logic [6:0]  r;
		logic [14:0] p;
		logic [3:0]  t;
		logic [3:0]  o;
		h = (v >= 8'd200) ? 2'd2 : ((v >= 8'd100) ? 2'd1 : 2'd0);
		r = 7'(v - 8'(h) * 8'd100);
		p = 15'(r) * 15'd205;
		t = p[14:11];
		o = 4'(r - 7'(t) * 7'd10);
		case (sel)
			2'd0: return 8'(h);
			2'd1: return 8'(t);
			default: return 8'(o);
		endcase
	endfunction

endpackage
`default_nettype wire

FILE: hdl/ce8_ram.sv
// Generic single-write, single-read memory with registered read data.
// No dependencies.
`default_nettype none
module ce8_ram #(
	parameter int W  = 8,
	parameter int D  = 4096,
	parameter int AW = $clog2(D)
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [W-1:0]  wdata,
	input  wire logic [AW-1:0] raddr,
	output logic      [W-1:0]  rdata
);

	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

FILE: hdl/ce8_alu.sv
// Shared 8-bit arithmetic and logic unit for register operations and compares.
// Depends on ce8_pkg.
`default_nettype none
module ce8_alu import ce8_pkg::*; (
	input  wire alu_op_t    op,
	input  wire logic [7:0] a,
	input  wire logic [7:0] b,
	output logic      [7:0] res,
	output logic            flag
);

	logic [8:0] sum;

	assign sum = {1'b0, a} + {1'b0, b};

	always_comb begin
		res  = b;
		flag = 1'b0;
		case (op)
			ALU_MOV:  res = b;
			ALU_OR:   res = a | b;
			ALU_AND:  res = a & b;
			ALU_XOR:  res = a ^ b;
			ALU_ADD: begin
				res  = sum[7:0];
				flag = sum[8];
			end
			ALU_SUB: begin
				res  = a - b;
				flag = (a >= b);
			end
			ALU_SHR: begin
				res  = {1'b0, a[7:1]};
				flag = a[0];
			end
			ALU_SUBN: begin
				res  = b - a;
				flag = (b >= a);
			end
			ALU_SHL: begin
				res  = {a[6:0], 1'b0};
				flag = a[7];
			end
			default: res = b;
		endcase
	end

endmodule
`default_nettype wire

FILE: hdl/chip8_execution_core_unit.sv
// Top level of the CHIP-8 execution core: sequencer, registers, stack, timers.
// Depends on ce8_pkg, ce8_ram (main store and screen) and ce8_alu.
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------
//  in      | in_valid / in_stall  | func address data_byte key_index key_down
//          |                      | random_byte pixel_row pixel_col
//  out     | out_valid/ out_stall | status pc_value pixel_value sound_active
//  cfg     | cfg_valid/ cfg_ready | start_address
//
// One item at a time. Memory write, key and tick items go straight to S_DONE, a pixel
// read via S_PX. An instruction runs S_F0, S_F1, S_F2, S_RY, S_EX, S_DONE plus its extra
// work: screen clear one S_CLS step per row, sprite draw S_D0, S_D1, S_D2 per row, FX33
// one S_BCD step per digit, FX55 S_ST0, S_ST1 and FX65 S_LD0, S_LD1 per register, a VF
// write S_VF. After reset a clearing pass loads the font and clears memory and screen,
// in_stall high meanwhile. A result waits in the output register while out_stall holds.
`default_nettype none
module chip8_execution_core_unit import ce8_pkg::*; (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	input  wire logic [2:0]    func,
	input  wire logic [AW-1:0] address,
	input  wire logic [7:0]    data_byte,
	input  wire logic [3:0]    key_index,
	input  wire logic          key_down,
	input  wire logic [7:0]    random_byte,
	input  wire logic [4:0]    pixel_row,
	input  wire logic [5:0]    pixel_col,
	output logic               out_valid,
	input  wire logic          out_stall,
	output logic [2:0]         status,
	output logic [AW-1:0]      pc_value,
	output logic               pixel_value,
	output logic               sound_active,
	input  wire logic          cfg_valid,
	output logic               cfg_ready,
	input  wire logic [AW-1:0] start_address
);

	localparam logic [4:0] S_INIT = 5'd0;
	localparam logic [4:0] S_IDLE = 5'd1;
	localparam logic [4:0] S_DONE = 5'd2;
	localparam logic [4:0] S_PX   = 5'd3;
	localparam logic [4:0] S_F0   = 5'd4;
	localparam logic [4:0] S_F1   = 5'd5;
	localparam logic [4:0] S_F2   = 5'd6;
	localparam logic [4:0] S_RY   = 5'd7;
	localparam logic [4:0] S_EX   = 5'd8;
	localparam logic [4:0] S_VF   = 5'd9;
	localparam logic [4:0] S_CLS  = 5'd10;
	localparam logic [4:0] S_D0   = 5'd11;
	localparam logic [4:0] S_D1   = 5'd12;
	localparam logic [4:0] S_D2   = 5'd13;
	localparam logic [4:0] S_BCD  = 5'd14;
	localparam logic [4:0] S_ST0  = 5'd15;
	localparam logic [4:0] S_ST1  = 5'd16;
	localparam logic [4:0] S_LD0  = 5'd17;
	localparam logic [4:0] S_LD1  = 5'd18;

	logic [4:0]      state_q;
	logic [AW-1:0]   cnt_q;
	logic [AW-1:0]   pc_q;
	logic [15:0]     i_q;
	logic [SP_W-1:0] sp_q;
	logic [2:0]      halt_q;
	logic [4:0]      wait_q;
	logic [7:0]      delay_q;
	logic [7:0]      sound_q;
	logic [15:0]     keys_q;
	logic [7:0]      hi_q;
	logic [7:0]      lo_q;
	logic [7:0]      vx_q;
	logic [4:0]      row_q;
	logic [7:0]      line_q;
	logic            hit_q;
	logic            flag_q;
	logic            pix_q;
	logic [7:0]      rnd_q;
	logic [5:0]      pcol_q;
	logic [7:0]      v_q [16];
	logic [7:0]      vrd_q;
	logic [AW-1:0]   stack_q [STACK_DEPTH];
	logic            out_valid_q;
	logic [2:0]      status_q;
	logic [AW-1:0]   pcv_q;
	logic            pixv_q;
	logic            snd_q;

	logic            mem_we;
	logic [AW-1:0]   mem_wa;
	logic [7:0]      mem_wd;
	logic [AW-1:0]   mem_ra;
	logic [7:0]      mem_rd;
	logic            fr_we;
	logic [4:0]      fr_wa;
	logic [COLS-1:0] fr_wd;
	logic [4:0]      fr_ra;
	logic [COLS-1:0] fr_rd;
	logic            v_we;
	logic [3:0]      v_wa;
	logic [7:0]      v_wd;
	logic [3:0]      v_ra;
	alu_op_t         alu_op;
	logic [7:0]      alu_a;
	logic [7:0]      alu_b;
	logic [7:0]      alu_res;
	logic            alu_flag;

	logic            acc;
	logic [3:0]      top;
	logic [3:0]      x;
	logic [3:0]      y;
	logic [3:0]      n;
	logic [AW-1:0]   nnn;
	logic [7:0]      vy;
	logic [AW-1:0]   pc2;
	logic [AW-1:0]   pc4;
	logic [AW-1:0]   iaddr;
	logic [4:0]      draw_row;
	logic [COLS-1:0] mask;
	logic            eq;
	logic            flag_op;
	logic [2:0]      ex_err;
	logic [16:0]     i_sum;
	logic            out_load;

	assign acc      = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign top      = hi_q[7:4];
	assign x        = hi_q[3:0];
	assign y        = lo_q[7:4];
	assign n        = lo_q[3:0];
	assign nnn      = {hi_q[3:0], lo_q};
	assign vy       = vrd_q;
	assign pc2      = pc_q + AW'(2);
	assign pc4      = pc_q + AW'(4);
	assign iaddr    = i_q[AW-1:0] + cnt_q;
	assign draw_row = row_q + cnt_q[4:0];
	assign mask     = sprite_mask(line_q, vx_q[5:0]);
	assign eq       = (alu_res == 8'd0);
	assign i_sum    = {1'b0, i_q} + 17'(vx_q);
	assign flag_op  = (n == 4'h4) || (n == 4'h5) || (n == 4'h6) || (n == 4'h7) || (n == 4'hE);
	assign out_load = (state_q == S_DONE) && (!out_valid_q || !out_stall);

	ce8_ram #(.W(8), .D(MEM_BYTES)) u_main (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_wa),
		.wdata (mem_wd),
		.raddr (mem_ra),
		.rdata (mem_rd)
	);

	ce8_ram #(.W(COLS), .D(ROWS)) u_frame (
		.clk   (clk),
		.we    (fr_we),
		.waddr (fr_wa),
		.wdata (fr_wd),
		.raddr (fr_ra),
		.rdata (fr_rd)
	);

	ce8_alu u_alu (
		.op   (alu_op),
		.a    (alu_a),
		.b    (alu_b),
		.res  (alu_res),
		.flag (alu_flag)
	);

	// Operand selection for the shared unit; skips compare through XOR.
	always_comb begin
		alu_a  = vx_q;
		alu_b  = vy;
		alu_op = ALU_XOR;
		case (top)
			4'h3, 4'h4: alu_b = lo_q;
			4'h7: begin
				alu_b  = lo_q;
				alu_op = ALU_ADD;
			end
			4'h8: begin
				case (n)
					4'h0: alu_op = ALU_MOV;
					4'h1: alu_op = ALU_OR;
					4'h2: alu_op = ALU_AND;
					4'h4: alu_op = ALU_ADD;
					4'h5: alu_op = ALU_SUB;
					4'h6: alu_op = ALU_SHR;
					4'h7: alu_op = ALU_SUBN;
					4'hE: alu_op = ALU_SHL;
					default: alu_op = ALU_XOR;
				endcase
			end
			4'hC: begin
				alu_a  = rnd_q;
				alu_b  = lo_q;
				alu_op = ALU_AND;
			end
			default: alu_op = ALU_XOR;
		endcase
	end

	always_comb begin
		ex_err = ST_OK;
		case (top)
			4'h0: begin
				if (lo_q == 8'hE0) begin
					ex_err = ST_OK;
				end else if (lo_q == 8'hEE) begin
					if (sp_q == '0) ex_err = ST_BAD_RET;
				end else begin
					ex_err = (hi_q == 8'h00 && lo_q == 8'h00) ? ST_HALT : ST_ILLEGAL;
				end
			end
			4'h2: if (sp_q >= SP_W'(STACK_DEPTH)) ex_err = ST_OVERFLOW;
			4'h8: if (!(flag_op || n == 4'h0 || n == 4'h1 || n == 4'h2 || n == 4'h3))
				ex_err = ST_ILLEGAL;
			4'hD: if (({1'b0, i_q} + 17'(n)) > 17'd4096) ex_err = ST_BAD_SPRITE;
			4'hE: if (n != 4'hE && n != 4'h1) ex_err = ST_ILLEGAL;
			4'hF: begin
				case (n)
					4'h7, 4'hA, 4'h8, 4'hE, 4'h9, 4'h3: ex_err = ST_OK;
					4'h5: if (y != 4'h1 && y != 4'h5 && y != 4'h6) ex_err = ST_ILLEGAL;
					default: ex_err = ST_ILLEGAL;
				endcase
			end
			default: ex_err = ST_OK;
		endcase
	end

	// Memory, screen and register-file ports per sequencer step.
	always_comb begin
		mem_we = 1'b0;
		mem_wa = iaddr;
		mem_wd = vrd_q;
		mem_ra = iaddr;
		fr_we  = 1'b0;
		fr_wa  = draw_row;
		fr_wd  = fr_rd ^ mask;
		fr_ra  = draw_row;
		v_we   = 1'b0;
		v_wa   = x;
		v_wd   = alu_res;
		v_ra   = 4'h0;
		case (state_q)
			S_INIT: begin
				mem_we = 1'b1;
				mem_wa = cnt_q;
				mem_wd = font_byte(cnt_q);
				fr_we  = 1'b1;
				fr_wa  = cnt_q[4:0];
				fr_wd  = '0;
			end
			S_IDLE: begin
				fr_ra = pixel_row;
				if (acc && func == FN_MEMWR) begin
					mem_we = 1'b1;
					mem_wa = address;
					mem_wd = data_byte;
				end
				if (acc && func == FN_KEY && key_down && wait_q[4]) begin
					v_we = 1'b1;
					v_wa = wait_q[3:0];
					v_wd = {4'h0, key_index};
				end
			end
			S_F0: mem_ra = pc_q;
			S_F1: mem_ra = pc_q + AW'(1);
			S_F2: v_ra = x;
			S_RY: v_ra = (top == 4'hB) ? 4'h0 : y;
			S_EX: begin
				if (ex_err == ST_OK) begin
					case (top)
						4'h6: begin
							v_we = 1'b1;
							v_wd = lo_q;
						end
						4'h7, 4'h8, 4'hC: v_we = 1'b1;
						4'hD: begin
							if (n == 4'h0) begin
								v_we = 1'b1;
								v_wa = 4'hF;
								v_wd = 8'd0;
							end
						end
						4'hF: begin
							if (n == 4'h7) begin
								v_we = 1'b1;
								v_wd = delay_q;
							end
						end
						default: v_we = 1'b0;
					endcase
				end
			end
			S_VF: begin
				v_we = 1'b1;
				v_wa = 4'hF;
				v_wd = {7'd0, flag_q};
			end
			S_CLS: begin
				fr_we = 1'b1;
				fr_wa = cnt_q[4:0];
				fr_wd = '0;
			end
			S_D2: fr_we = 1'b1;
			S_BCD: begin
				mem_we = 1'b1;
				mem_wd = bcd_digit(vx_q, cnt_q[1:0]);
			end
			S_ST0: v_ra = cnt_q[3:0];
			S_ST1: mem_we = 1'b1;
			S_LD1: begin
				v_we = 1'b1;
				v_wa = cnt_q[3:0];
				v_wd = mem_rd;
			end
			default: mem_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 16; k++) begin
				v_q[k] <= 8'd0;
			end
			vrd_q <= 8'd0;
		end else begin
			if (v_we) begin
				v_q[v_wa] <= v_wd;
			end
			vrd_q <= v_q[v_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_EX && ex_err == ST_OK && top == 4'h2) begin
			stack_q[sp_q[SI_W-1:0]] <= pc2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			cnt_q       <= '0;
			pc_q        <= RESET_START;
			i_q         <= '0;
			sp_q        <= '0;
			halt_q      <= ST_OK;
			wait_q      <= '0;
			delay_q     <= '0;
			sound_q     <= '0;
			keys_q      <= '0;
			hi_q        <= '0;
			lo_q        <= '0;
			vx_q        <= '0;
			row_q       <= '0;
			line_q      <= '0;
			hit_q       <= 1'b0;
			flag_q      <= 1'b0;
			pix_q       <= 1'b0;
			rnd_q       <= '0;
			pcol_q      <= '0;
			out_valid_q <= 1'b0;
			status_q    <= ST_OK;
			pcv_q       <= '0;
			pixv_q      <= 1'b0;
			snd_q       <= 1'b0;
		end else begin
			case (state_q)
				S_INIT: begin
					cnt_q <= cnt_q + AW'(1);
					if (cnt_q == AW'(MEM_BYTES - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (acc) begin
						rnd_q   <= random_byte;
						pcol_q  <= pixel_col;
						pix_q   <= 1'b0;
						cnt_q   <= '0;
						state_q <= S_DONE;
						case (func)
							FN_STEP: begin
								if (halt_q == ST_OK && !wait_q[4]) state_q <= S_F0;
							end
							FN_KEY: begin
								keys_q[key_index] <= key_down;
								if (key_down && wait_q[4]) begin
									wait_q <= '0;
									pc_q   <= pc2;
								end
							end
							FN_TICK: begin
								if (delay_q != 8'd0) delay_q <= delay_q - 8'd1;
								if (sound_q != 8'd0) sound_q <= sound_q - 8'd1;
							end
							FN_PIXEL: state_q <= S_PX;
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_PX: begin
					pix_q   <= fr_rd[pcol_q];
					state_q <= S_DONE;
				end
				S_F0: state_q <= S_F1;
				S_F1: begin
					hi_q    <= mem_rd;
					state_q <= S_F2;
				end
				S_F2: begin
					lo_q    <= mem_rd;
					state_q <= S_RY;
				end
				S_RY: begin
					vx_q    <= vrd_q;
					state_q <= S_EX;
				end
				S_EX: begin
					state_q <= S_DONE;
					if (ex_err != ST_OK) begin
						halt_q <= ex_err;
					end else begin
						pc_q <= pc2;
						case (top)
							4'h0: begin
								if (lo_q == 8'hE0) begin
									state_q <= S_CLS;
								end else begin
									sp_q <= sp_q - SP_W'(1);
									pc_q <= stack_q[SI_W'(sp_q - SP_W'(1))];
								end
							end
							4'h1: pc_q <= nnn;
							4'h2: begin
								sp_q <= sp_q + SP_W'(1);
								pc_q <= nnn;
							end
							4'h3, 4'h5: if (eq) pc_q <= pc4;
							4'h4, 4'h9: if (!eq) pc_q <= pc4;
							4'h8: begin
								if (flag_op) begin
									flag_q  <= alu_flag;
									state_q <= S_VF;
								end
							end
							4'hA: i_q <= 16'(nnn);
							4'hB: pc_q <= nnn + AW'(vy);
							4'hD: begin
								row_q <= vy[4:0];
								hit_q <= 1'b0;
								if (n != 4'h0) state_q <= S_D0;
							end
							4'hE: begin
								if (keys_q[vx_q[3:0]] == (n == 4'hE)) pc_q <= pc4;
							end
							4'hF: begin
								case (n)
									4'hA: begin
										wait_q <= {1'b1, x};
										pc_q   <= pc_q;
									end
									4'h8: sound_q <= vx_q;
									4'hE: begin
										i_q     <= i_sum[15:0];
										flag_q  <= (i_sum > 17'hFFF);
										state_q <= S_VF;
									end
									4'h9: i_q <= 16'({vx_q, 2'b00}) + 16'(vx_q);
									4'h3: state_q <= S_BCD;
									4'h5: begin
										if (y == 4'h1) delay_q <= vx_q;
										else if (y == 4'h5) state_q <= S_ST0;
										else state_q <= S_LD0;
									end
									default: state_q <= S_DONE;
								endcase
							end
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_VF: state_q <= S_DONE;
				S_CLS: begin
					cnt_q <= cnt_q + AW'(1);
					if (cnt_q[4:0] == 5'(ROWS - 1)) state_q <= S_DONE;
				end
				S_D0: state_q <= S_D1;
				S_D1: begin
					line_q  <= mem_rd;
					state_q <= S_D2;
				end
				S_D2: begin
					// collect collisions, then hand the flag to the VF write
					hit_q <= hit_q | (|(fr_rd & mask));
					cnt_q <= cnt_q + AW'(1);
					if (cnt_q[3:0] == n - 4'd1) begin
						flag_q  <= hit_q | (|(fr_rd & mask));
						state_q <= S_VF;
					end else begin
						state_q <= S_D0;
					end
				end
				S_BCD: begin
					cnt_q <= cnt_q + AW'(1);
					if (cnt_q[1:0] == 2'd2) state_q <= S_DONE;
				end
				S_ST0: state_q <= S_ST1;
				S_ST1: begin
					cnt_q   <= cnt_q + AW'(1);
					state_q <= (cnt_q[3:0] == x) ? S_DONE : S_ST0;
				end
				S_LD0: state_q <= S_LD1;
				S_LD1: begin
					cnt_q   <= cnt_q + AW'(1);
					state_q <= (cnt_q[3:0] == x) ? S_DONE : S_LD0;
				end
				S_DONE: begin
					if (out_load) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase

			// hold the result until taken
			if (out_load) begin
				out_valid_q <= 1'b1;
				status_q    <= (halt_q != ST_OK) ? halt_q : (wait_q[4] ? ST_WAIT_KEY : ST_OK);
				pcv_q       <= pc_q;
				pixv_q      <= pix_q;
				snd_q       <= (sound_q != 8'd0);
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			if (cfg_valid) begin
				pc_q <= start_address;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign pc_value     = pcv_q;
	assign pixel_value  = pixv_q;
	assign sound_active = snd_q;

endmodule
`default_nettype wire
